@@ hw/rtl/tpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared widths, codes and control types of the task priority queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

  // Default sizing
  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 8;

  // Fixed port field widths
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Control from the front end to the sequencer
  typedef struct packed {
    logic start;  // item accepted this cycle
    logic op;     // operation of that item
    logic ack;    // finished result taken into the output register
  } tpq_ctl_t;

  // Status from the sequencer to the front end
  typedef struct packed {
    logic                busy;    // item in progress, no new item taken
    logic                fin;     // result ready to be loaded
    logic [STATUS_W-1:0] status;  // status of that result
  } tpq_sts_t;

endpackage

@@ hw/rtl/tpq_ram.sv @@
// ----------------------------------------------------------------------------
// tpq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tpq_seq.sv @@
// ----------------------------------------------------------------------------
// tpq_seq
// Sequencer of the sorted queue: walks the entry RAM one entry a cycle,
// shifting entries up on insert and down on remove, and keeps head and count.
// ----------------------------------------------------------------------------
module tpq_seq
  import tpq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int PW = PRIORITY_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tpq_ctl_t        ctl,
  input  logic [ID_W-1:0] new_id,
  input  logic [PW-1:0]   new_prio,
  output tpq_sts_t        sts,
  output logic [ID_W-1:0] rem_id,
  output logic [PW-1:0]   rem_prio,
  output logic [ID_W-1:0] head_id,
  output logic [PW-1:0]   head_prio,
  output logic [CW-1:0]   count
);

  localparam int EW = ID_W + PW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [ID_W-1:0]     head_id_r, head_id_nxt;
  logic [PW-1:0]       head_prio_r, head_prio_nxt;
  logic [ID_W-1:0]     ins_id_r, ins_id_nxt;
  logic [PW-1:0]       ins_prio_r, ins_prio_nxt;
  logic [ID_W-1:0]     rem_id_r, rem_id_nxt;
  logic [PW-1:0]       rem_prio_r, rem_prio_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [ID_W-1:0] rd_id;
  logic [PW-1:0]   rd_prio;
  logic [CW-1:0]   cnt_m1;
  logic            full;

  assign rd_id   = rdata[EW-1:PW];
  assign rd_prio = rdata[PW-1:0];
  assign cnt_m1  = count_r - CW'(1);
  assign full    = (count_r == CW'(QUEUE_DEPTH));

  tpq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequencer: one entry read, compared and moved per cycle
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    head_id_nxt   = head_id_r;
    head_prio_nxt = head_prio_r;
    ins_id_nxt    = ins_id_r;
    ins_prio_nxt  = ins_prio_r;
    rem_id_nxt    = rem_id_r;
    rem_prio_nxt  = rem_prio_r;
    status_nxt    = status_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          rem_id_nxt   = '0;
          rem_prio_nxt = '0;
          status_nxt   = ST_OK;
          if (ctl.op == OP_INSERT) begin
            ins_id_nxt   = new_id;
            ins_prio_nxt = new_prio;
            if (full) begin
              // drop the task, queue unchanged
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              count_nxt = count_r + CW'(1);
              if (count_r == '0 || new_prio < head_prio_r) begin
                head_id_nxt   = new_id;
                head_prio_nxt = new_prio;
              end
              if (count_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = {new_id, new_prio};
                state_nxt = S_FIN;
              end else begin
                // walk down from the tail
                re        = 1'b1;
                raddr     = cnt_m1[AW-1:0];
                ptr_nxt   = cnt_m1[AW-1:0];
                state_nxt = S_INS;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              rem_id_nxt   = head_id_r;
              rem_prio_nxt = head_prio_r;
              count_nxt    = cnt_m1;
              if (count_r == CW'(1)) begin
                state_nxt = S_FIN;
              end else begin
                // walk up from the second entry
                re        = 1'b1;
                raddr     = AW'(1);
                ptr_nxt   = AW'(1);
                state_nxt = S_REM;
              end
            end
          end
        end
      end
      S_INS: begin
        we = 1'b1;
        if (rd_prio > ins_prio_r) begin
          // move entry up one place, keep walking
          waddr = ptr_r + AW'(1);
          wdata = rdata;
          if (ptr_r == '0) begin
            state_nxt = S_INS0;
          end else begin
            re      = 1'b1;
            raddr   = ptr_r - AW'(1);
            ptr_nxt = ptr_r - AW'(1);
          end
        end else begin
          // ties stay ahead of the new task
          waddr     = ptr_r + AW'(1);
          wdata     = {ins_id_r, ins_prio_r};
          state_nxt = S_FIN;
        end
      end
      S_INS0: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = {ins_id_r, ins_prio_r};
        state_nxt = S_FIN;
      end
      S_REM: begin
        we    = 1'b1;
        waddr = ptr_r - AW'(1);
        wdata = rdata;
        if (ptr_r == AW'(1)) begin
          head_id_nxt   = rd_id;
          head_prio_nxt = rd_prio;
        end
        if (CW'(ptr_r) == count_r) begin
          state_nxt = S_FIN;
        end else begin
          re      = 1'b1;
          raddr   = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_FIN: begin
        if (ctl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working and head registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    head_id_r   <= head_id_nxt;
    head_prio_r <= head_prio_nxt;
    ins_id_r    <= ins_id_nxt;
    ins_prio_r  <= ins_prio_nxt;
    rem_id_r    <= rem_id_nxt;
    rem_prio_r  <= rem_prio_nxt;
    status_r    <= status_nxt;
  end

  assign sts.busy   = (state_r != S_IDLE);
  assign sts.fin    = (state_r == S_FIN);
  assign sts.status = status_r;
  assign rem_id     = rem_id_r;
  assign rem_prio   = rem_prio_r;
  assign head_id    = head_id_r;
  assign head_prio  = head_prio_r;
  assign count      = count_r;

endmodule

@@ hw/rtl/task_priority_queue.sv @@
// Insert and remove times are set by the walk over the entry RAM (one entry per
// cycle through its single read port); empty, full and one-entry cases skip the walk.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register. Reset (rst_n, synchronous): queue empty, no result.
// ----------------------------------------------------------------------------
// task_priority_queue
// Ready-task priority queue kept sorted in a RAM; lower priority value first,
// equal priorities in arrival order. Reports head and count on every result.
// ----------------------------------------------------------------------------
module task_priority_queue
  import tpq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = DEPTH_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [ID_W-1:0]     in_task_id,
  input  logic [PRIO_W-1:0]   in_task_priority,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_removed_id,
  output logic [PRIO_W-1:0]   out_removed_priority,
  output logic                out_head_valid,
  output logic [ID_W-1:0]     out_head_id,
  output logic [PRIO_W-1:0]   out_head_priority,
  output logic [COUNT_W-1:0]  out_entry_count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = PRIORITY_BITS;

  tpq_ctl_t            ctl;
  tpq_sts_t            sts;
  logic [PW-1:0]       new_prio;
  logic [31:0]         prio_ext;
  logic [ID_W-1:0]     rem_id, head_id;
  logic [PW-1:0]       rem_prio, head_prio;
  logic [CW-1:0]       count;
  logic [31:0]         rem_prio_ext, head_prio_ext, count_ext;
  logic                in_acc, load;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [ID_W-1:0]     rem_id_r, head_id_r;
  logic [PRIO_W-1:0]   rem_prio_r, head_prio_r;
  logic                head_valid_r;
  logic [COUNT_W-1:0]  count_r;

  // Input handshake and priority masking
  assign in_stall = sts.busy;
  assign in_acc   = in_valid && !in_stall;
  assign prio_ext = 32'(in_task_priority);
  assign new_prio = prio_ext[PW-1:0];

  // Load the result when the output register is free or being emptied
  assign load = sts.fin && (!out_valid_r || !out_stall);

  assign ctl.start = in_acc;
  assign ctl.op    = in_opcode;
  assign ctl.ack   = load;

  tpq_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .new_id   (in_task_id),
    .new_prio (new_prio),
    .sts      (sts),
    .rem_id   (rem_id),
    .rem_prio (rem_prio),
    .head_id  (head_id),
    .head_prio(head_prio),
    .count    (count)
  );

  assign rem_prio_ext  = 32'(rem_prio);
  assign head_prio_ext = 32'(head_prio);
  assign count_ext     = 32'(count);

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; head reads zero on an empty queue
  always_ff @(posedge clk) begin
    if (load) begin
      status_r     <= sts.status;
      rem_id_r     <= rem_id;
      rem_prio_r   <= rem_prio_ext[PRIO_W-1:0];
      head_valid_r <= (count != '0);
      head_id_r    <= (count != '0) ? head_id : '0;
      head_prio_r  <= (count != '0) ? head_prio_ext[PRIO_W-1:0] : '0;
      count_r      <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_removed_id       = rem_id_r;
  assign out_removed_priority = rem_prio_r;
  assign out_head_valid       = head_valid_r;
  assign out_head_id          = head_id_r;
  assign out_head_priority    = head_prio_r;
  assign out_entry_count      = count_r;

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("block not busy after accepting an item");

  // A loaded result shows up on the output channel
  a_result_shown : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded result not presented");

  // The entry count never exceeds the queue depth
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

endmodule
